FILE: design/bpps_pkg.sv
// Shared types, constants and helpers of the BPSK polyphase pulse shaper.
package bpps_pkg;

	// Default configuration of the filter
	localparam int unsigned DEF_SPS    = 20;
	localparam int unsigned DEF_TAPS   = 10;
	localparam int unsigned DEF_COEF_W = 16;

	// Fixed field widths
	localparam int unsigned IDX_W    = 8;
	localparam int unsigned VALUE_W  = 16;
	localparam int unsigned AMP_W    = 15;
	localparam int unsigned LINE_W   = 16;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned FRAC_BITS = 15;

	localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(15000);

	// Entries in the queue between front and engine (power of two)
	localparam int unsigned QUEUE_DEPTH = 2;

	// Item kinds
	typedef enum logic {
		MODE_TICK = 1'b0,
		MODE_COEF = 1'b1
	} mode_t;

	// Carrier weights of the fs/4 sequence
	typedef enum logic [1:0] {
		CARR_POS  = 2'd0,
		CARR_ZERO = 2'd1,
		CARR_NEG  = 2'd2
	} carrier_t;

	// One queued item
	typedef struct packed {
		mode_t               mode;
		logic                symbol_bit;
		logic [IDX_W-1:0]    coef_index;
		logic [VALUE_W-1:0]  coef_value;
	} item_t;

	// Carrier 1, 0, -1, 0 indexed by phase modulo 4
	function automatic carrier_t carrier_of(input logic [1:0] ph);
		carrier_t c;
		unique case (ph)
			2'd0:    c = CARR_POS;
			2'd2:    c = CARR_NEG;
			default: c = CARR_ZERO;
		endcase
		return c;
	endfunction

endpackage

FILE: design/bpsk_polyphase_pulse_shaper.sv
// Top level of the impulse-modulated BPSK transmitter with polyphase pulse shaping.
// Each input item is either a coefficient write (mode 1) or a sample tick (mode 0). A write
// to an address at or beyond SAMPLES_PER_SYMBOL*TAPS_PER_PHASE is accepted and dropped;
// a write gives no output. A tick gives one sample: at phase zero the symbol bit enters
// the symbol line as -/+ symbol_amplitude, then TAPS_PER_PHASE products of the line and
// the coefficients of the current phase are summed, floored by 2^15, multiplied by the
// fs/4 carrier 1,0,-1,0 and saturated to 16 bits. A coefficient write is taken by the engine
// while it is idle; a tick walks the taps in turn through the single shared multiplier and
// the one read port of the coefficient store. A two-entry queue lets input transfers
// continue while the engine works, and the output register lets the next tick compute while
// a sample waits to be taken. The coefficient store has no reset: every coefficient must be
// written before the first tick that uses it. The user is to write symbol_amplitude on the
// cfg channel only while the block is idle; the block itself does not enforce it.
module bpsk_polyphase_pulse_shaper import bpps_pkg::*; #(
	parameter int unsigned SAMPLES_PER_SYMBOL = DEF_SPS,
	parameter int unsigned TAPS_PER_PHASE     = DEF_TAPS,
	parameter int unsigned COEF_WIDTH         = DEF_COEF_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [AMP_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       mode,
	input  logic                       symbol_bit,
	input  logic [IDX_W-1:0]           coef_index,
	input  logic signed [VALUE_W-1:0]  coef_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] sample
);

	logic [AMP_W-1:0] amp_q;
	logic             q_valid;
	logic             q_pop;
	item_t            q_item;

	// Symbol amplitude register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q <= AMP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			amp_q <= cfg_data;
		end
	end

	bpps_front #(
		.COEF_DEPTH (SAMPLES_PER_SYMBOL * TAPS_PER_PHASE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.symbol_bit (symbol_bit),
		.coef_index (coef_index),
		.coef_value (VALUE_W'(coef_value)),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	bpps_engine #(
		.SAMPLES_PER_SYMBOL (SAMPLES_PER_SYMBOL),
		.TAPS_PER_PHASE     (TAPS_PER_PHASE),
		.COEF_WIDTH         (COEF_WIDTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.amplitude (amp_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample)
	);

endmodule

FILE: design/bpps_front.sv
// Front end: accepts input items, drops out-of-range coefficient writes, queues the rest.
module bpps_front import bpps_pkg::*; #(
	parameter int unsigned COEF_DEPTH = DEF_SPS * DEF_TAPS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic               symbol_bit,
	input  logic [IDX_W-1:0]   coef_index,
	input  logic [VALUE_W-1:0] coef_value,
	output logic               q_valid,
	output item_t              q_item,
	input  logic               q_pop
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t              q_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               full;
	logic               keep;
	logic               push;
	item_t              item_in;

	// Classify: ticks always go on, writes only inside the store
	always_comb begin
		item_in.mode       = mode_t'(mode);
		item_in.symbol_bit = symbol_bit;
		item_in.coef_index = coef_index;
		item_in.coef_value = coef_value;
		keep = (item_in.mode == MODE_TICK) || (32'(coef_index) < COEF_DEPTH);
	end

	assign full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign in_ready = !full;
	assign push     = in_valid && in_ready && keep;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = q_mem[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= item_in;
		end
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (q_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/bpps_engine.sv
// Back end: coefficient store, symbol line, shared multiply-accumulate and output register.
module bpps_engine import bpps_pkg::*; #(
	parameter int unsigned SAMPLES_PER_SYMBOL = DEF_SPS,
	parameter int unsigned TAPS_PER_PHASE     = DEF_TAPS,
	parameter int unsigned COEF_WIDTH         = DEF_COEF_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  item_t                      q_item,
	output logic                       q_pop,
	input  logic [AMP_W-1:0]           amplitude,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] sample
);

	localparam int unsigned DEPTH  = SAMPLES_PER_SYMBOL * TAPS_PER_PHASE;
	localparam int unsigned AW     = $clog2(DEPTH);
	localparam int unsigned PW     = $clog2(SAMPLES_PER_SYMBOL);
	localparam int unsigned TW     = $clog2(TAPS_PER_PHASE);
	localparam int unsigned PROD_W = LINE_W + COEF_WIDTH;
	localparam int unsigned RAW_W  = PROD_W + TW + 1;
	localparam int unsigned SUM_W  = (RAW_W > 32) ? RAW_W : 32;
	localparam int unsigned FL_W   = SUM_W - FRAC_BITS;

	localparam logic signed [FL_W:0] SAT_HI = (FL_W + 1)'(32767);
	localparam logic signed [FL_W:0] SAT_LO = -(FL_W + 1)'(32768);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_DONE = 3'b100
	} eng_state_t;

	eng_state_t                 state_q;
	logic [PW-1:0]              phase_q;
	logic signed [LINE_W-1:0]   line_q [TAPS_PER_PHASE];
	logic [COEF_WIDTH-1:0]      coef_mem [DEPTH];

	logic                       issue_q;
	logic [AW-1:0]              addr_q;
	logic [TW-1:0]              tap_q;
	logic                       v_s1;
	logic                       last_s1;
	logic [TW-1:0]              tap_s1;
	logic signed [COEF_WIDTH-1:0] rdata_s1;
	logic                       v_s2;
	logic                       last_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [SUM_W-1:0]    acc_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	logic                       tick_start;
	logic                       coef_we;
	logic                       done_fire;
	logic                       last_phase;
	logic                       last_tap;
	logic [PW-1:0]              next_phase;
	logic signed [FL_W-1:0]     floor_v;
	logic signed [FL_W:0]       floor_x;
	logic signed [FL_W:0]       mod_x;
	logic signed [SAMPLE_W-1:0] sat_v;

	assign q_pop      = q_valid && (state_q == S_IDLE);
	assign tick_start = q_pop && (q_item.mode == MODE_TICK);
	assign coef_we    = q_pop && (q_item.mode == MODE_COEF);
	assign done_fire  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign last_phase = (phase_q == PW'(SAMPLES_PER_SYMBOL - 1));
	assign next_phase = last_phase ? '0 : phase_q + 1'b1;
	assign last_tap   = (tap_q == TW'(TAPS_PER_PHASE - 1));
	assign out_valid  = out_valid_q;
	assign sample     = sample_q;

	// Coefficient store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[AW'(q_item.coef_index)] <= COEF_WIDTH'(q_item.coef_value);
		end
		rdata_s1 <= coef_mem[addr_q];
	end

	// MAC datapath: address walk, multiply, accumulate
	always_ff @(posedge clk) begin
		if (tick_start) begin
			addr_q <= AW'(phase_q);
			tap_q  <= '0;
			acc_q  <= '0;
		end else begin
			if (issue_q) begin
				addr_q <= addr_q + AW'(SAMPLES_PER_SYMBOL);
				tap_q  <= tap_q + 1'b1;
			end
			if (v_s2) begin
				acc_q <= acc_q + SUM_W'(prod_s2);
			end
		end
		tap_s1  <= tap_q;
		last_s1 <= last_tap;
		prod_s2 <= line_q[tap_s1] * rdata_s1;
		last_s2 <= last_s1;
	end

	// Scale, apply carrier, saturate
	always_comb begin
		floor_v = acc_q[SUM_W-1:FRAC_BITS];
		floor_x = {floor_v[FL_W-1], floor_v};
		unique case (carrier_of(next_phase[1:0]))
			CARR_POS: mod_x = floor_x;
			CARR_NEG: mod_x = -floor_x;
			default:  mod_x = '0;
		endcase
		priority if (mod_x > SAT_HI) begin
			sat_v = SAMPLE_W'(32767);
		end else if (mod_x < SAT_LO) begin
			sat_v = -SAMPLE_W'(32768);
		end else begin
			sat_v = mod_x[SAMPLE_W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (done_fire) begin
			sample_q <= sat_v;
		end
	end

	// Control: sequencer, phase, symbol line, pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= '0;
			issue_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int t = 0; t < TAPS_PER_PHASE; t++) begin
				line_q[t] <= '0;
			end
		end else begin
			v_s1 <= issue_q;
			v_s2 <= v_s1;
			if (issue_q && last_tap) begin
				issue_q <= 1'b0;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (tick_start) begin
						state_q <= S_RUN;
						issue_q <= 1'b1;
						if (phase_q == '0) begin
							line_q[0] <= q_item.symbol_bit ? LINE_W'(amplitude)
								: -LINE_W'(amplitude);
						end
					end
				end
				S_RUN: begin
					if (v_s2 && last_s2) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (done_fire) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						phase_q     <= next_phase;
						if (last_phase) begin
							for (int t = 1; t < TAPS_PER_PHASE; t++) begin
								line_q[t] <= line_q[t-1];
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	ap_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(phase_q) < SAMPLES_PER_SYMBOL)
		else $error("phase counter out of range");

	ap_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> (!issue_q && !v_s1 && !v_s2))
		else $error("result taken while products still in flight");

	ap_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		coef_we |-> (!issue_q && !v_s1 && !v_s2))
		else $error("coefficient write during a dot product");

	ap_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done_fire |=> $stable(phase_q))
		else $error("phase moved without a finished tick");

	ap_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && !done_fire) |=> $stable(sample_q))
		else $error("pending sample overwritten");
`endif

endmodule

FILE: bench/bpsk_polyphase_pulse_shaper_tb.sv
// Self-checking testbench for the BPSK polyphase pulse shaper, with predictor and scoreboard.
`timescale 1ns / 100ps

module bpsk_polyphase_pulse_shaper_tb;
	import bpps_pkg::*;

	localparam int SPS     = DEF_SPS;
	localparam int TAPS    = DEF_TAPS;
	localparam int N_COEFS = DEF_SPS * DEF_TAPS;
	localparam int SETTLE  = 40;

	// Ways to fill the coefficient store
	typedef enum int {
		FILL_RANDOM,
		FILL_SMALL,
		FILL_MAX,
		FILL_MIN
	} coef_fill_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [AMP_W-1:0]           cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic                       mode;
	logic                       symbol_bit;
	logic [IDX_W-1:0]           coef_index;
	logic signed [VALUE_W-1:0]  coef_value;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] sample;

	// Predictor state
	logic signed [VALUE_W-1:0]  coef_mem [N_COEFS];
	logic signed [LINE_W-1:0]   sym_line [TAPS];
	int unsigned                phase;
	logic [AMP_W-1:0]           amplitude;

	logic signed [SAMPLE_W-1:0] expected_samples [$];
	logic signed [SAMPLE_W-1:0] want;
	int                         errors = 0;
	bit                         steady = 1'b0;

	bpsk_polyphase_pulse_shaper dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.symbol_bit (symbol_bit),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample     (sample)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Output back-pressure
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 16);
	end

	// One sample tick of the shaper: symbol entry, dot product, shift, carrier, saturation
	function automatic logic signed [SAMPLE_W-1:0] shape_sample(input logic sb);
		longint acc;
		longint y;
		int     a;
		a = amplitude;
		if (phase == 0)
			sym_line[0] = sb ? LINE_W'(a) : LINE_W'(-a);
		acc = 0;
		for (int t = 0; t < TAPS; t++)
			acc += longint'(sym_line[t]) * longint'(coef_mem[phase + SPS * t]);
		if (phase == SPS - 1) begin
			for (int t = TAPS - 1; t > 0; t--)
				sym_line[t] = sym_line[t - 1];
			phase = 0;
		end else begin
			phase++;
		end
		// floor by 2^15, then carrier picked by the advanced phase
		y = acc >>> FRAC_BITS;
		case (carrier_of(2'(phase)))
			CARR_POS:  y = y;
			CARR_NEG:  y = -y;
			default:   y = 0;
		endcase
		if (y > 32767)
			y = 32767;
		if (y < -32768)
			y = -32768;
		return SAMPLE_W'(y);
	endfunction

	// Result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				errors++;
				$display("%0t: sample %0d arrived with none expected", $time, sample);
			end else begin
				want = expected_samples.pop_front();
				if (sample !== want) begin
					errors++;
					$display("%0t: sample mismatch, expected %0d, got %0d", $time, want, sample);
				end
			end
		end
	end

	// One input transfer, with random idling ahead of it
	task automatic send_item(input mode_t m, input logic sb, input logic [IDX_W-1:0] idx,
			input logic [VALUE_W-1:0] val);
		while (!steady && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		symbol_bit <= sb;
		coef_index <= idx;
		coef_value <= val;
		do
			@(posedge clk);
		while (!in_ready);
		if (m == MODE_COEF) begin
			if (idx < N_COEFS)
				coef_mem[idx] = val;
		end else begin
			expected_samples.push_back(shape_sample(sb));
		end
	endtask

	task automatic send_tick(input logic sb);
		send_item(MODE_TICK, sb, IDX_W'($urandom), VALUE_W'($urandom));
	endtask

	// Wait until every sample is in and the engine has gone quiet
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_amplitude(input logic [AMP_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		amplitude = v;
		@(posedge clk);
	endtask

	task automatic load_coefs(input coef_fill_t fill);
		int v;
		for (int k = 0; k < N_COEFS; k++) begin
			case (fill)
				FILL_SMALL: v = int'($urandom_range(0, 4000)) - 2000;
				FILL_MAX:   v = 32767;
				FILL_MIN:   v = -32768;
				default:    v = $urandom;
			endcase
			send_item(MODE_COEF, 1'($urandom), IDX_W'(k), VALUE_W'(v));
		end
	endtask

	// Reset amplitude, ignored writes, field extremes, a full symbol plus one
	task automatic test_first_symbols();
		load_coefs(FILL_RANDOM);
		send_item(MODE_COEF, 1'b0, IDX_W'(N_COEFS), 16'h7fff);
		send_item(MODE_COEF, 1'b1, 8'hff, 16'h8000);
		send_item(MODE_COEF, 1'b0, 8'd0, 16'h8000);
		send_item(MODE_COEF, 1'b1, IDX_W'(N_COEFS - 1), 16'h7fff);
		send_tick(1'b1);
		for (int k = 1; k < SPS; k++)
			send_tick(1'($urandom));
		send_tick(1'b0);
		drain();
	endtask

	// Full amplitude against full-scale coefficients of both signs
	task automatic test_saturation();
		write_amplitude(AMP_W'(32767));
		load_coefs(FILL_MAX);
		for (int k = 0; k < 2 * SPS; k++)
			send_tick(1'($urandom));
		load_coefs(FILL_MIN);
		for (int k = 0; k < 2 * SPS; k++)
			send_tick(1'($urandom));
		drain();
	endtask

	task automatic test_zero_amplitude();
		write_amplitude('0);
		load_coefs(FILL_RANDOM);
		for (int k = 0; k < SPS + 5; k++)
			send_tick(1'($urandom));
		drain();
	endtask

	// Mostly ticks with coefficient rewrites mixed in; one burst without idling
	task automatic test_random_traffic();
		for (int p = 0; p < 5; p++) begin
			write_amplitude(AMP_W'($urandom));
			if (p == 1)
				load_coefs(FILL_SMALL);
			else if (p == 3)
				load_coefs(FILL_RANDOM);
			steady = (p == 2);
			for (int k = 0; k < 24; k++) begin
				if ($urandom_range(0, 99) < 15)
					send_item(MODE_COEF, 1'($urandom), IDX_W'($urandom), VALUE_W'($urandom));
				else
					send_tick(1'($urandom));
			end
			drain();
			steady = 1'b0;
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		mode       = MODE_TICK;
		symbol_bit = 1'b0;
		coef_index = '0;
		coef_value = '0;
		amplitude  = AMP_RESET;
		phase      = 0;
		for (int t = 0; t < TAPS; t++)
			sym_line[t] = '0;
		for (int k = 0; k < N_COEFS; k++)
			coef_mem[k] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_symbols();
		test_saturation();
		test_zero_amplitude();
		test_random_traffic();

		drain();
		if (expected_samples.size() != 0) begin
			errors++;
			$display("%0t: %0d samples never arrived", $time, expected_samples.size());
		end
		if (errors == 0)
			$display("bpsk_polyphase_pulse_shaper_tb: done, clean");
		else
			$display("bpsk_polyphase_pulse_shaper_tb: done, errors");
		$finish;
	end

	// Watchdog
	initial begin
		#3_000_000;
		$display("bpsk_polyphase_pulse_shaper_tb: done, errors");
		$finish;
	end

endmodule
